>>> hdl/lcts_pkg.sv
`default_nettype none
package lcts_pkg;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int LED_OUT_BITS   = 5;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_DEBOUNCE     = 4'd0;
  localparam cfg_index_t REG_STARTUP      = 4'd1;
  localparam cfg_index_t REG_SLEEP_DELAY  = 4'd2;
  localparam cfg_index_t REG_IDLE_TIMEOUT = 4'd3;
  localparam cfg_index_t REG_FLASH_LIMIT  = 4'd4;
  localparam cfg_index_t REG_RUN_MIN      = 4'd5;
  localparam cfg_index_t REG_RUN_MAX      = 4'd6;
  localparam cfg_index_t REG_RUN_START    = 4'd7;

  localparam logic [15:0] RST_DEBOUNCE     = 16'd500;
  localparam logic [15:0] RST_STARTUP      = 16'd5000;
  localparam logic [15:0] RST_SLEEP_DELAY  = 16'd1000;
  localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd20000;
  localparam logic [7:0]  RST_FLASH_LIMIT  = 8'd20;
  localparam logic [7:0]  RST_RUN_MIN      = 8'd20;
  localparam logic [7:0]  RST_RUN_MAX      = 8'd70;
  localparam logic [7:0]  RST_RUN_START    = 8'd55;
  localparam logic [7:0]  RST_RUN_PERIOD   = 8'd50;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] startup_ms;
    logic [15:0] sleep_delay_ms;
    logic [15:0] idle_timeout_ms;
    logic [7:0]  flash_cycle_limit;
    logic [7:0]  run_min_period;
    logic [7:0]  run_max_period;
    logic [7:0]  run_start_period;
  } cfg_t;

  typedef struct packed {
    logic [LED_OUT_BITS-1:0] led_pattern;
    logic                    asleep;
    logic                    flash_active;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/lcts_core.sv
`default_nettype none
module lcts_core #(
  parameter int LED_COUNT    = 5,
  parameter int FLASH_PERIOD = 20,
  parameter int TIME_BITS    = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          raw,
  input  lcts_pkg::cfg_t     cfg,
  output lcts_pkg::res_t     res
);
  import lcts_pkg::*;

  localparam int PW = $clog2(LED_COUNT);

  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] last_change_r, last_change_nxt;
  logic [TIME_BITS-1:0] run_last_r, run_last_nxt;
  logic [TIME_BITS-1:0] flash_last_r, flash_last_nxt;
  logic                 last_raw_r, last_raw_nxt;
  logic                 stable_r, stable_nxt;
  logic                 sleeping_r, sleeping_nxt;
  logic                 level_at_sleep_r, level_at_sleep_nxt;
  logic                 active_valid_r, active_valid_nxt;
  logic                 active_flash_r, active_flash_nxt;
  logic [PW-1:0]        run_pos_r, run_pos_nxt;
  logic                 run_dir_down_r, run_dir_down_nxt;
  logic [7:0]           run_cycles_r, run_cycles_nxt;
  logic [7:0]           run_period_r, run_period_nxt;
  logic                 run_ramp_up_r, run_ramp_up_nxt;
  logic                 flash_phase_r, flash_phase_nxt;
  logic [7:0]           flash_cycles_r, flash_cycles_nxt;
  logic [LED_COUNT-1:0] led_r, led_nxt;

  logic [TIME_BITS-1:0] elapsed_change;
  logic [TIME_BITS-1:0] elapsed_run;
  logic [TIME_BITS-1:0] elapsed_flash;
  logic [7:0]           led_wide;

  assign elapsed_change = now_r - last_change_r;
  assign elapsed_run    = now_r - run_last_r;
  assign elapsed_flash  = now_r - flash_last_r;

  always_comb begin
    logic                 want_flash;
    logic                 sleep_now;
    logic [TIME_BITS-1:0] since_change;
    logic signed [9:0]    period_step;
    now_nxt            = now_r;
    last_change_nxt    = last_change_r;
    run_last_nxt       = run_last_r;
    flash_last_nxt     = flash_last_r;
    last_raw_nxt       = last_raw_r;
    stable_nxt         = stable_r;
    sleeping_nxt       = sleeping_r;
    level_at_sleep_nxt = level_at_sleep_r;
    active_valid_nxt   = active_valid_r;
    active_flash_nxt   = active_flash_r;
    run_pos_nxt        = run_pos_r;
    run_dir_down_nxt   = run_dir_down_r;
    run_cycles_nxt     = run_cycles_r;
    run_period_nxt     = run_period_r;
    run_ramp_up_nxt    = run_ramp_up_r;
    flash_phase_nxt    = flash_phase_r;
    flash_cycles_nxt   = flash_cycles_r;
    led_nxt            = led_r;
    want_flash         = 1'b0;
    sleep_now          = 1'b0;
    since_change       = '0;
    period_step        = '0;
    if (sleeping_r) begin
      if (raw != level_at_sleep_r) begin
        last_change_nxt = now_r;
        last_raw_nxt    = raw;
        stable_nxt      = raw;
        sleeping_nxt    = 1'b0;
      end
    end else begin
      if (last_raw_r != raw) begin
        last_change_nxt = now_r;
        last_raw_nxt    = raw;
        since_change    = '0;
      end else begin
        since_change = elapsed_change;
        if (elapsed_change > TIME_BITS'(cfg.debounce_ms)) begin
          stable_nxt = last_raw_r;
        end
      end
      sleep_now = (now_r > TIME_BITS'(cfg.startup_ms)) &&
                  ((stable_nxt && (since_change > TIME_BITS'(cfg.sleep_delay_ms))) ||
                   (since_change > TIME_BITS'(cfg.idle_timeout_ms)));
      if (sleep_now) begin
        led_nxt            = '0;
        sleeping_nxt       = 1'b1;
        level_at_sleep_nxt = raw;
      end else begin
        want_flash = (now_r >= TIME_BITS'(cfg.startup_ms)) && stable_nxt;
        if (!active_valid_r || (active_flash_r != want_flash)) begin
          led_nxt          = '0;
          active_valid_nxt = 1'b1;
          active_flash_nxt = want_flash;
          if (want_flash) begin
            flash_phase_nxt  = 1'b0;
            flash_cycles_nxt = '0;
          end else begin
            run_pos_nxt    = '0;
            run_cycles_nxt = '0;
            run_period_nxt = cfg.run_start_period;
          end
        end
        if (want_flash) begin
          if (elapsed_flash > TIME_BITS'(FLASH_PERIOD)) begin
            if (flash_phase_nxt) begin
              flash_phase_nxt  = 1'b0;
              flash_cycles_nxt = flash_cycles_nxt + 8'd1;
            end else begin
              flash_phase_nxt = 1'b1;
            end
            flash_last_nxt = now_r;
            led_nxt        = flash_phase_nxt ? '1 : '0;
          end
          if (flash_cycles_nxt == cfg.flash_cycle_limit) begin
            led_nxt            = '0;
            sleeping_nxt       = 1'b1;
            level_at_sleep_nxt = raw;
          end
        end else if (elapsed_run > TIME_BITS'(run_period_nxt)) begin
          led_nxt[run_pos_nxt] = 1'b0;
          if (run_dir_down_r) begin
            if (run_pos_nxt == '0) begin
              run_pos_nxt    = PW'(LED_COUNT - 1);
              run_cycles_nxt = run_cycles_nxt + 8'd1;
            end else begin
              run_pos_nxt = run_pos_nxt - PW'(1);
            end
          end else begin
            if (run_pos_nxt == PW'(LED_COUNT - 1)) begin
              run_pos_nxt    = '0;
              run_cycles_nxt = run_cycles_nxt + 8'd1;
            end else begin
              run_pos_nxt = run_pos_nxt + PW'(1);
            end
          end
          run_last_nxt         = now_r;
          led_nxt[run_pos_nxt] = 1'b1;
          period_step = $signed({2'b00, run_period_nxt}) +
                        (run_ramp_up_r ? 10'sd1 : -10'sd1);
          if (period_step < $signed({2'b00, cfg.run_min_period})) begin
            run_ramp_up_nxt = 1'b1;
            period_step     = $signed({2'b00, cfg.run_min_period});
          end else if (period_step > $signed({2'b00, cfg.run_max_period})) begin
            period_step      = $signed({2'b00, cfg.run_max_period});
            run_ramp_up_nxt  = 1'b0;
            run_dir_down_nxt = ~run_dir_down_r;
          end
          run_period_nxt = period_step[7:0];
        end
      end
      now_nxt = now_r + TIME_BITS'(1);
    end
  end

  assign led_wide         = 8'(led_nxt);
  assign res.led_pattern  = led_wide[LED_OUT_BITS-1:0];
  assign res.asleep       = sleeping_nxt;
  assign res.flash_active = active_valid_nxt & active_flash_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r            <= '0;
      last_change_r    <= '0;
      run_last_r       <= '0;
      flash_last_r     <= '0;
      last_raw_r       <= 1'b0;
      stable_r         <= 1'b0;
      sleeping_r       <= 1'b0;
      level_at_sleep_r <= 1'b0;
      active_valid_r   <= 1'b0;
      active_flash_r   <= 1'b0;
      run_pos_r        <= '0;
      run_dir_down_r   <= 1'b0;
      run_cycles_r     <= '0;
      run_period_r     <= RST_RUN_PERIOD;
      run_ramp_up_r    <= 1'b0;
      flash_phase_r    <= 1'b0;
      flash_cycles_r   <= '0;
      led_r            <= '0;
    end else if (en) begin
      now_r            <= now_nxt;
      last_change_r    <= last_change_nxt;
      run_last_r       <= run_last_nxt;
      flash_last_r     <= flash_last_nxt;
      last_raw_r       <= last_raw_nxt;
      stable_r         <= stable_nxt;
      sleeping_r       <= sleeping_nxt;
      level_at_sleep_r <= level_at_sleep_nxt;
      active_valid_r   <= active_valid_nxt;
      active_flash_r   <= active_flash_nxt;
      run_pos_r        <= run_pos_nxt;
      run_dir_down_r   <= run_dir_down_nxt;
      run_cycles_r     <= run_cycles_nxt;
      run_period_r     <= run_period_nxt;
      run_ramp_up_r    <= run_ramp_up_nxt;
      flash_phase_r    <= flash_phase_nxt;
      flash_cycles_r   <= flash_cycles_nxt;
      led_r            <= led_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/led_chaser_with_tilt_sleep.sv
`default_nettype none
// LED chaser with tilt-sensor sleep. Each input item is one millisecond tick with the raw
// sensor level, and each one yields exactly one result item with the LED pattern, the sleep
// flag and the flash flag after that tick. An item is captured in an input register and its
// whole state update is done in one pass into the result register, so the block takes one
// item per clock and its result is valid on the outputs after the input and result registers;
// the only limit is the result register, which holds while out_stall is high. Configuration
// writes take effect at once and are meant to be made while no item is in flight.
module led_chaser_with_tilt_sleep #(
  parameter int LED_COUNT    = 5,
  parameter int FLASH_PERIOD = 20,
  parameter int TIME_BITS    = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_sensor_raw,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [lcts_pkg::LED_OUT_BITS-1:0]       out_led_pattern,
  output logic                                    out_asleep,
  output logic                                    out_flash_active,
  input  wire logic                               cfg_we,
  input  wire logic [lcts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lcts_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import lcts_pkg::*;

  cfg_t cfg_r;
  res_t res;
  logic in_valid_r;
  logic in_raw_r;
  logic advance;

  assign advance  = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= RST_DEBOUNCE;
      cfg_r.startup_ms        <= RST_STARTUP;
      cfg_r.sleep_delay_ms    <= RST_SLEEP_DELAY;
      cfg_r.idle_timeout_ms   <= RST_IDLE_TIMEOUT;
      cfg_r.flash_cycle_limit <= RST_FLASH_LIMIT;
      cfg_r.run_min_period    <= RST_RUN_MIN;
      cfg_r.run_max_period    <= RST_RUN_MAX;
      cfg_r.run_start_period  <= RST_RUN_START;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     cfg_r.debounce_ms       <= cfg_wdata;
        REG_STARTUP:      cfg_r.startup_ms        <= cfg_wdata;
        REG_SLEEP_DELAY:  cfg_r.sleep_delay_ms    <= cfg_wdata;
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout_ms   <= cfg_wdata;
        REG_FLASH_LIMIT:  cfg_r.flash_cycle_limit <= cfg_wdata[7:0];
        REG_RUN_MIN:      cfg_r.run_min_period    <= cfg_wdata[7:0];
        REG_RUN_MAX:      cfg_r.run_max_period    <= cfg_wdata[7:0];
        REG_RUN_START:    cfg_r.run_start_period  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_raw_r <= in_sensor_raw;
    end
  end

  lcts_core #(
    .LED_COUNT    (LED_COUNT),
    .FLASH_PERIOD (FLASH_PERIOD),
    .TIME_BITS    (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .raw   (in_raw_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led_pattern  <= res.led_pattern;
      out_asleep       <= res.asleep;
      out_flash_active <= res.flash_active;
    end
  end

  a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_asleep |-> out_led_pattern == '0)
    else $error("LEDs lit while asleep");

  a_run_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_asleep && !out_flash_active |-> $onehot0(out_led_pattern))
    else $error("more than one LED lit in run animation");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("item processed without a result");

endmodule
`default_nettype wire

>>> verif/tb_led_chaser_with_tilt_sleep.sv
`timescale 1ns / 100ps

module tb_led_chaser_with_tilt_sleep;
  import lcts_pkg::*;

  localparam int LEDS        = 5;
  localparam int FLASH_MS    = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_sensor_raw = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LED_OUT_BITS-1:0] out_led_pattern;
  logic out_asleep;
  logic out_flash_active;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = REG_DEBOUNCE;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  led_chaser_with_tilt_sleep u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sensor_raw(in_sensor_raw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_led_pattern(out_led_pattern),
    .out_asleep(out_asleep),
    .out_flash_active(out_flash_active),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow copy of the registers and of the chaser state.
  cfg_t cfg = '{RST_DEBOUNCE, RST_STARTUP, RST_SLEEP_DELAY, RST_IDLE_TIMEOUT,
                RST_FLASH_LIMIT, RST_RUN_MIN, RST_RUN_MAX, RST_RUN_START};
  logic [31:0] clock_ms = '0;
  logic [31:0] changed_at_ms = '0;
  logic [31:0] dot_at_ms = '0;
  logic [31:0] blink_at_ms = '0;
  logic sensor_seen = 1'b0;
  logic sensor_stable = 1'b0;
  logic dozing = 1'b0;
  logic wake_ref = 1'b0;
  logic anim_live = 1'b0;
  logic anim_flash = 1'b0;
  logic [2:0] dot_pos = '0;
  logic [2:0] dot_prev = '0;
  logic dot_down = 1'b0;
  logic dot_slowing = 1'b0;
  logic [7:0] dot_laps = '0;
  logic [7:0] dot_period = RST_RUN_PERIOD;
  logic blink_on = 1'b0;
  logic [7:0] blink_laps = '0;
  logic [LED_OUT_BITS-1:0] leds = '0;

  res_t expected_results[$];
  logic pending_ticks[$];
  int ticks_planned = 0;
  int ticks_taken = 0;
  int results_seen = 0;
  int miss_count = 0;
  int asleep_results = 0;
  int flash_results = 0;
  int settings_loaded = 0;
  int cycle_count = 0;
  int in_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit no_idle = 1'b0;
  logic in_fire = 1'b0;

  function automatic void doze_off(logic raw);
    leds = '0;
    dozing = 1'b1;
    wake_ref = raw;
  endfunction

  function automatic void advance_chaser();
    int p;
    if (clock_ms - dot_at_ms <= dot_period) return;
    dot_prev = dot_pos;
    if (dot_down) begin
      if (dot_pos == 0) begin
        dot_pos = 3'(LEDS - 1);
        dot_laps = dot_laps + 8'd1;
      end else begin
        dot_pos = dot_pos - 3'd1;
      end
    end else begin
      if (dot_pos + 1 >= LEDS) begin
        dot_pos = '0;
        dot_laps = dot_laps + 8'd1;
      end else begin
        dot_pos = dot_pos + 3'd1;
      end
    end
    dot_at_ms = clock_ms;
    leds[dot_prev] = 1'b0;
    leds[dot_pos] = 1'b1;
    p = int'(dot_period) + (dot_slowing ? 1 : -1);
    if (p < int'(cfg.run_min_period)) begin
      dot_slowing = 1'b1;
      p = int'(cfg.run_min_period);
    end else if (p > int'(cfg.run_max_period)) begin
      p = int'(cfg.run_max_period);
      dot_slowing = 1'b0;
      dot_down = ~dot_down;
    end
    dot_period = 8'(p);
  endfunction

  function automatic void advance_blink();
    if (clock_ms - blink_at_ms <= FLASH_MS) return;
    if (blink_on) begin
      blink_on = 1'b0;
      blink_laps = blink_laps + 8'd1;
    end else begin
      blink_on = 1'b1;
    end
    blink_at_ms = clock_ms;
    leds = blink_on ? '1 : '0;
  endfunction

  function automatic res_t predict_tick(logic raw);
    logic [31:0] quiet;
    logic flash_wanted;
    res_t r;
    if (dozing) begin
      if (raw != wake_ref) begin
        changed_at_ms = clock_ms;
        sensor_seen = raw;
        sensor_stable = raw;
        dozing = 1'b0;
      end
    end else begin
      if (sensor_seen != raw) begin
        changed_at_ms = clock_ms;
        sensor_seen = raw;
      end else if (clock_ms - changed_at_ms > cfg.debounce_ms) begin
        sensor_stable = sensor_seen;
      end
      quiet = clock_ms - changed_at_ms;
      if (clock_ms > cfg.startup_ms &&
          ((sensor_stable && quiet > cfg.sleep_delay_ms) || quiet > cfg.idle_timeout_ms)) begin
        doze_off(raw);
      end else begin
        flash_wanted = (clock_ms >= cfg.startup_ms) && sensor_stable;
        if (!anim_live || anim_flash != flash_wanted) begin
          leds = '0;
          anim_live = 1'b1;
          anim_flash = flash_wanted;
          if (flash_wanted) begin
            blink_on = 1'b0;
            blink_laps = '0;
          end else begin
            dot_pos = '0;
            dot_prev = '0;
            dot_laps = '0;
            dot_period = cfg.run_start_period;
          end
        end
        if (flash_wanted) begin
          advance_blink();
          if (blink_laps == cfg.flash_cycle_limit) doze_off(raw);
        end else begin
          advance_chaser();
        end
      end
      clock_ms = clock_ms + 32'd1;
    end
    r.led_pattern = leds;
    r.asleep = dozing;
    r.flash_active = anim_live & anim_flash;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_tick(logic level);
    pending_ticks.push_back(level);
    ticks_planned++;
  endfunction

  // Mostly level holds of random length, some of them long enough to pass
  // debounce and the timeouts, mixed with short bursts of sensor noise.
  function automatic void plan_ticks(int count);
    int left;
    int len;
    logic level;
    level = 1'($urandom_range(0, 1));
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 6);
        if (len > left) len = left;
        repeat (len) add_tick(1'($urandom_range(0, 1)));
      end else begin
        level = ~level;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 10);
        if (len > left) len = left;
        repeat (len) add_tick(level);
      end
      left -= len;
    end
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEBOUNCE:     cfg.debounce_ms = val;
      REG_STARTUP:      cfg.startup_ms = val;
      REG_SLEEP_DELAY:  cfg.sleep_delay_ms = val;
      REG_IDLE_TIMEOUT: cfg.idle_timeout_ms = val;
      REG_FLASH_LIMIT:  cfg.flash_cycle_limit = val[7:0];
      REG_RUN_MIN:      cfg.run_min_period = val[7:0];
      REG_RUN_MAX:      cfg.run_max_period = val[7:0];
      REG_RUN_START:    cfg.run_start_period = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(cfg_t s);
    write_reg(REG_DEBOUNCE, s.debounce_ms);
    write_reg(REG_STARTUP, s.startup_ms);
    write_reg(REG_SLEEP_DELAY, s.sleep_delay_ms);
    write_reg(REG_IDLE_TIMEOUT, s.idle_timeout_ms);
    write_reg(REG_FLASH_LIMIT, {8'd0, s.flash_cycle_limit});
    write_reg(REG_RUN_MIN, {8'd0, s.run_min_period});
    write_reg(REG_RUN_MAX, {8'd0, s.run_max_period});
    write_reg(REG_RUN_START, {8'd0, s.run_start_period});
    settings_loaded++;
    @(posedge clk);
  endtask

  task automatic drain();
    do @(negedge clk); while (ticks_taken != ticks_planned || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_ticks.size() != 0) begin
        in_valid <= 1'b1;
        in_sensor_raw <= pending_ticks.pop_front();
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 250 && in_fire) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : scoreboard
    res_t got;
    res_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      got.led_pattern = out_led_pattern;
      got.asleep = out_asleep;
      got.flash_active = out_flash_active;
      if (expected_results.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("Result %0d came with nothing expected: led=%b asleep=%b flash=%b",
                   results_seen, got.led_pattern, got.asleep, got.flash_active);
      end else begin
        want = expected_results.pop_front();
        if (want.asleep) asleep_results++;
        if (want.flash_active) flash_results++;
        if (got.led_pattern !== want.led_pattern || got.asleep !== want.asleep ||
            got.flash_active !== want.flash_active) begin
          miss_count++;
          if (miss_count <= 10)
            $display("Result %0d: expected led=%b asleep=%b flash=%b, got led=%b asleep=%b flash=%b",
                     results_seen, want.led_pattern, want.asleep, want.flash_active,
                     got.led_pattern, got.asleep, got.flash_active);
        end
      end
      results_seen++;
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(predict_tick(in_sensor_raw));
      ticks_taken++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d of %0d items accepted.",
               cycle_count, ticks_taken, ticks_planned);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t plan [7];
    bit opening [20];
    plan[0] = '{16'd2, 16'd10, 16'd100, 16'd200, 8'd1, 8'd1, 8'd4, 8'd2};
    plan[1] = '{16'd0, 16'd0, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    plan[2] = '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 8'd1, 8'd1, 8'd1, 8'd1};
    plan[3] = '{16'd5, 16'd20, 16'd60, 16'd150, 8'd2, 8'd9, 8'd3, 8'd6};
    plan[4] = '{16'd3, 16'd0, 16'd30, 16'd90, 8'd3, 8'd2, 8'd6, 8'd4};
    plan[5].debounce_ms = 16'($urandom_range(0, 12));
    plan[5].startup_ms = 16'($urandom_range(0, 40));
    plan[5].sleep_delay_ms = 16'($urandom_range(20, 120));
    plan[5].idle_timeout_ms = 16'($urandom_range(60, 300));
    plan[5].flash_cycle_limit = 8'($urandom_range(1, 4));
    plan[5].run_min_period = 8'($urandom_range(1, 8));
    plan[5].run_max_period = 8'($urandom_range(1, 12));
    plan[5].run_start_period = 8'($urandom_range(1, 12));
    plan[6] = '{RST_DEBOUNCE, RST_STARTUP, RST_SLEEP_DELAY, RST_IDLE_TIMEOUT,
                RST_FLASH_LIMIT, RST_RUN_MIN, RST_RUN_MAX, RST_RUN_START};
    opening = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 1, 0, 0, 0, 0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: a few toggles under the power-on settings.
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b1);
    add_tick(1'b0);
    drain();

    // Fast stepping, idle timeout into sleep, asleep ticks, wake, flash start.
    load_setting('{16'd0, 16'd2, 16'd65535, 16'd6, 8'd1, 8'd1, 8'd2, 8'd1});
    foreach (opening[i]) add_tick(opening[i]);
    drain();

    for (int k = 0; k < 7; k++) begin
      load_setting(plan[k]);
      no_idle = (k == 2);
      plan_ticks(k == 6 ? 70 : 160);
      drain();
    end
    no_idle = 1'b0;

    repeat (10) @(negedge clk);
    $display("Run covered %0d ticks under %0d register settings, %0d results checked.",
             ticks_taken, settings_loaded, results_seen);
    $display("%0d results were asleep, %0d had the flash animation active, %0d mismatches.",
             asleep_results, flash_results, miss_count);
    if (miss_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
